>>> hw/rtl/sesc_pkg.sv
// ----------------------------------------------------------------------------
// sesc_pkg: shared types and codes for the string escaper
// Item structs, configuration codes, job descriptor and output slot layout.
// ----------------------------------------------------------------------------
package sesc_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT   = 1'b1;

	// escape_mode codes; the unused code behaves as pass-through
	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_C    = 2'd1;
	localparam logic [1:0] MODE_JSON = 2'd2;

	// how one output unit is spelled
	typedef enum logic [1:0] {
		ENC_LIT = 2'd0,  // the byte itself
		ENC_ESC = 2'd1,  // backslash, one character
		ENC_OCT = 2'd2,  // backslash, three octal digits
		ENC_HEX = 2'd3   // backslash, u, four uppercase hex digits
	} enc_t;

	// output slots of one job, emitted in this order
	localparam int SLOT_N     = 7;
	localparam int SLOT_OPEN  = 0;
	localparam int SLOT_PRE0  = 1;
	localparam int SLOT_PRE1  = 2;
	localparam int SLOT_MAIN  = 3;
	localparam int SLOT_POST0 = 4;
	localparam int SLOT_POST1 = 5;
	localparam int SLOT_CLOSE = 6;

	localparam logic [15:0] UNIT_REPL = 16'hFFFD;
	localparam logic [7:0]  CH_QUOTE  = 8'h22;

	typedef struct packed {
		logic [SLOT_N-1:0] mask;  // slots present; PRE/POST slots are U+FFFD
		enc_t              enc;   // spelling of the main slot
		logic [15:0]       val;
		logic              last;
	} job_t;

endpackage

>>> hw/rtl/sesc_front.sv
// ----------------------------------------------------------------------------
// sesc_front: input side of the string escaper
// Holds configuration and UTF-8 decoder state, classifies each input byte
// into a job descriptor and pushes it to the job queue when it has any slot.
// ----------------------------------------------------------------------------
module sesc_front
	import sesc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  in_item_t              in_item,
	input  logic                  q_full,
	output logic                  q_push,
	output job_t                  q_job
);

	typedef struct packed {
		enc_t        enc;
		logic [15:0] val;
	} unit_t;

	logic [1:0]  mode_q;
	logic        eight_q;
	logic [1:0]  phase_q;
	logic [1:0]  pcnt_q;
	logic [15:0] part_q;

	logic [1:0]  phase_d;
	logic [1:0]  pcnt_d;
	logic [15:0] part_d;
	logic        accept;
	job_t        job;

	function automatic unit_t json_unit(input logic [15:0] u);
		unit_t r;
		r.enc = ENC_ESC;
		r.val = 16'h0000;
		case (u)
			16'h0008: r.val = 16'h0062;
			16'h000C: r.val = 16'h0066;
			16'h000A: r.val = 16'h006E;
			16'h000D: r.val = 16'h0072;
			16'h0009: r.val = 16'h0074;
			16'h0022: r.val = 16'h0022;
			16'h005C: r.val = 16'h005C;
			default: begin
				r.val = u;
				if (u >= 16'h0020 && u < 16'h007F)
					r.enc = ENC_LIT;
				else
					r.enc = ENC_HEX;
			end
		endcase
		return r;
	endfunction

	function automatic unit_t c_unit(input logic [7:0] b, input logic eight);
		unit_t r;
		r.enc = ENC_ESC;
		r.val = 16'h0000;
		case (b)
			8'h0D: r.val = 16'h0072;
			8'h0A: r.val = 16'h006E;
			8'h09: r.val = 16'h0074;
			8'h0B: r.val = 16'h0076;
			8'h08: r.val = 16'h0062;
			8'h0C: r.val = 16'h0066;
			8'h07: r.val = 16'h0061;
			8'h1B: r.val = 16'h0065;
			8'h22: r.val = 16'h0022;
			8'h5C: r.val = 16'h005C;
			default: begin
				r.val = {8'h00, b};
				if ((b >= 8'h20 && b < 8'h7F) || (eight && b > 8'h80))
					r.enc = ENC_LIT;
				else
					r.enc = ENC_OCT;
			end
		endcase
		return r;
	endfunction

	assign accept = push && !q_full;

	always_comb begin
		logic        cut;
		logic        fresh;
		logic [15:0] gathered;
		unit_t       u;
		cut      = in_item.first_byte || (mode_q != MODE_JSON);
		phase_d  = cut ? 2'd0 : phase_q;
		pcnt_d   = cut ? 2'd0 : pcnt_q;
		part_d   = cut ? 16'h0000 : part_q;
		fresh    = 1'b1;
		gathered = 16'h0000;
		u        = '{enc: ENC_LIT, val: 16'h0000};
		job      = '0;
		job.last = in_item.last_byte;

		if (mode_q != MODE_C && mode_q != MODE_JSON) begin
			job.mask[SLOT_MAIN] = 1'b1;
			job.enc             = ENC_LIT;
			job.val             = {8'h00, in_item.in_byte};
		end else begin
			job.mask[SLOT_OPEN]  = in_item.first_byte;
			job.mask[SLOT_CLOSE] = in_item.last_byte;
			if (mode_q == MODE_C) begin
				u = c_unit(in_item.in_byte, eight_q);
				job.mask[SLOT_MAIN] = 1'b1;
			end else begin
				if (phase_d != 2'd0) begin
					if (in_item.in_byte[7:6] == 2'b10) begin
						fresh    = 1'b0;
						gathered = part_d | ({10'h000, in_item.in_byte[5:0]}
							<< ((phase_d >= 2'd2) ? 6 : 0));
						phase_d  = phase_d - 2'd1;
						if (phase_d == 2'd0) begin
							u = json_unit(gathered);
							job.mask[SLOT_MAIN] = 1'b1;
							part_d = 16'h0000;
							pcnt_d = 2'd0;
						end else begin
							part_d = gathered;
							pcnt_d = pcnt_d + 2'd1;
						end
					end else begin
						// broken sequence: replacement for lead and taken bytes
						job.mask[SLOT_PRE0] = 1'b1;
						job.mask[SLOT_PRE1] = (pcnt_d != 2'd0);
						phase_d = 2'd0;
						pcnt_d  = 2'd0;
						part_d  = 16'h0000;
					end
				end
				if (fresh) begin
					pcnt_d = 2'd0;
					if (in_item.in_byte < 8'h80) begin
						u = json_unit({8'h00, in_item.in_byte});
						job.mask[SLOT_MAIN] = 1'b1;
					end else if (in_item.in_byte < 8'hC0) begin
						u = json_unit(UNIT_REPL);
						job.mask[SLOT_MAIN] = 1'b1;
					end else if (in_item.in_byte < 8'hE0) begin
						part_d  = {5'b00000, in_item.in_byte[4:0], 6'b000000};
						phase_d = 2'd1;
					end else if (in_item.in_byte < 8'hF0) begin
						part_d  = {in_item.in_byte[3:0], 12'h000};
						phase_d = 2'd2;
					end else begin
						u = json_unit(UNIT_REPL);
						job.mask[SLOT_MAIN] = 1'b1;
					end
				end
				// string ends inside a sequence
				if (in_item.last_byte && phase_d != 2'd0) begin
					job.mask[SLOT_POST0] = 1'b1;
					job.mask[SLOT_POST1] = (pcnt_d != 2'd0);
					phase_d = 2'd0;
					pcnt_d  = 2'd0;
					part_d  = 16'h0000;
				end
			end
			job.enc = u.enc;
			job.val = u.val;
		end
	end

	assign q_push = accept && (job.mask != '0);
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASS;
			eight_q <= 1'b0;
			phase_q <= 2'd0;
			pcnt_q  <= 2'd0;
			part_q  <= 16'h0000;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ESCAPE_MODE: mode_q  <= cfg_data;
					REG_EIGHT_BIT:   eight_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= phase_d;
				pcnt_q  <= pcnt_d;
				part_q  <= part_d;
			end
		end
	end

endmodule

>>> hw/rtl/sesc_queue.sv
// ----------------------------------------------------------------------------
// sesc_queue: job queue between classifier and output sequencer
// Small register FIFO; full is taken from the registered count.
// ----------------------------------------------------------------------------
module sesc_queue
	import sesc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic head_valid,
	output job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/sesc_back.sv
// ----------------------------------------------------------------------------
// sesc_back: output sequencer of the string escaper
// Walks the slots of the head job, spells each unit one byte per cycle
// while the output register is empty or popped, and loads the output register.
// ----------------------------------------------------------------------------
module sesc_back
	import sesc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  job_t      head,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	logic              busy_q;
	logic [SLOT_N-1:0] rem_q;
	logic [2:0]        pos_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [SLOT_N-1:0] rem;
	logic [SLOT_N-1:0] low;
	logic [SLOT_N-1:0] rem_nxt;
	enc_t              enc;
	logic [15:0]       val;
	logic [2:0]        len_m1;
	logic              unit_end;
	logic              job_end;
	logic              adv;
	logic [7:0]        byte_val;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	function automatic logic [7:0] unit_byte(input enc_t e, input logic [15:0] v,
			input logic [2:0] p);
		logic [7:0] r;
		r = 8'h5C;  // backslash opens every escape
		case (e)
			ENC_LIT: r = v[7:0];
			ENC_ESC: if (p != 3'd0) r = v[7:0];
			ENC_OCT: begin
				case (p)
					3'd1:    r = 8'h30 + {6'h00, v[7:6]};
					3'd2:    r = 8'h30 + {5'h00, v[5:3]};
					3'd3:    r = 8'h30 + {5'h00, v[2:0]};
					default: r = 8'h5C;
				endcase
			end
			ENC_HEX: begin
				case (p)
					3'd1:    r = 8'h75;
					3'd2:    r = hex_char(v[15:12]);
					3'd3:    r = hex_char(v[11:8]);
					3'd4:    r = hex_char(v[7:4]);
					3'd5:    r = hex_char(v[3:0]);
					default: r = 8'h5C;
				endcase
			end
			default: r = 8'h5C;
		endcase
		return r;
	endfunction

	assign rem     = busy_q ? rem_q : head.mask;
	assign low     = rem & (~rem + 1'b1);
	assign rem_nxt = rem & ~low;

	always_comb begin
		if (low[SLOT_OPEN] || low[SLOT_CLOSE]) begin
			enc = ENC_LIT;
			val = {8'h00, CH_QUOTE};
		end else if (low[SLOT_MAIN]) begin
			enc = head.enc;
			val = head.val;
		end else begin
			enc = ENC_HEX;
			val = UNIT_REPL;
		end
		case (enc)
			ENC_LIT: len_m1 = 3'd0;
			ENC_ESC: len_m1 = 3'd1;
			ENC_OCT: len_m1 = 3'd3;
			ENC_HEX: len_m1 = 3'd5;
			default: len_m1 = 3'd0;
		endcase
	end

	assign byte_val = unit_byte(enc, val, pos_q);
	assign unit_end = (pos_q == len_m1);
	assign job_end  = unit_end && (rem_nxt == '0);
	assign adv      = head_valid && (!out_valid_q || pop);
	assign q_pop    = adv && job_end;

	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			pos_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (job_end) begin
					busy_q <= 1'b0;
					pos_q  <= 3'd0;
				end else if (unit_end) begin
					busy_q <= 1'b1;
					rem_q  <= rem_nxt;
					pos_q  <= 3'd0;
				end else begin
					busy_q <= 1'b1;
					rem_q  <= rem;
					pos_q  <= pos_q + 3'd1;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_byte <= byte_val;
			out_q.out_last <= head.last && job_end;
		end
	end

endmodule

>>> hw/rtl/string_escape_utf8_json_c.sv
// The first output byte of an item passes through the job queue and then the
// output register before it is visible.
// Throughput: one output byte per cycle from the sequencer while the output
// register is empty or popped; an item spells up to 19 bytes (1 for plain text).
// Reset: config returns to pass-through, decoder state, queue and output clear.
// ----------------------------------------------------------------------------
// string_escape_utf8_json_c: quoted string escaper, C and JSON styles
// Classifier front end, job queue, byte sequencer with output register.
// ----------------------------------------------------------------------------
module string_escape_utf8_json_c
	import sesc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              in_item,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             out_item
);

	logic q_full;
	logic q_push;
	job_t q_job;
	logic q_pop;
	logic head_valid;
	job_t head;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	sesc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.in_item   (in_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	sesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (q_push),
		.wr_job     (q_job),
		.full       (q_full),
		.rd_en      (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_item   (out_item)
	);

endmodule

>>> hw/rtl/sesc_checker.sv
// ----------------------------------------------------------------------------
// sesc_checker: port-level checks for the string escaper
// Watches the queue-style ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module sesc_checker
	import sesc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (push && !full)
			seen_q <= 1'b1;
	end

	// a full job queue implies that a result is waiting at the output
	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input full while no result is waiting");

	// no result before any input transfer
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> seen_q)
		else $error("result shown before any input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("waiting result changed or vanished");

endmodule

bind string_escape_utf8_json_c sesc_checker u_sesc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
